FILE: rtl/twg_pkg.sv
// ----------------------------------------------------------------------------
// twg_pkg: shared types and constants for the table wave generator
// Item kinds, mode codes, register indexes, wave tables and the control
// structs between the sequencer, the divider and the sample store.
// ----------------------------------------------------------------------------
package twg_pkg;

  localparam int SAMPLES_PER_PERIOD = 20;
  localparam int ADDR_W     = $clog2(SAMPLES_PER_PERIOD);
  localparam int SAMPLE_W   = 10;
  localparam int DAC_W      = 8;
  localparam int POS_W      = 6;
  localparam int LED_W      = 2;
  localparam int KIND_W     = 2;
  localparam int TICK_W     = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int MODE_W     = 3;
  localparam int AMP_W      = 5;
  localparam int TAB_W      = 15;
  localparam int SCALED_W   = 20;

  // shared divider: two quotient bits per cycle
  localparam int DIV_W         = 26;
  localparam int DVS_W         = 17;
  localparam int DIV_STEP_BITS = 2;
  localparam int DIV_STEPS     = DIV_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_KNOB  = 2'd2;

  // wave modes
  localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SINE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TRIANGLE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RECORD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PLAYBACK = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_TEN_BIT = 2'd2;

  localparam logic [AMP_W-1:0]    AMP_MAX      = 5'd25;
  localparam logic [TICK_W-1:0]   PERIOD_RESET = 14'd10;
  localparam logic [SAMPLE_W-1:0] FS_TEN_BIT   = 10'd1023;
  localparam logic [SAMPLE_W-1:0] FS_EIGHT_BIT = 10'd255;

  localparam logic [SCALED_W-1:0] WAVE_GAIN    = 20'd51;
  localparam logic [DIV_W-1:0]    WAVE_BIAS    = 26'd50000;
  localparam logic [DVS_W-1:0]    WAVE_DIVISOR = 17'd100000;
  localparam logic [SCALED_W-1:0] PLAY_GAIN    = 20'd510;
  localparam logic [TAB_W-1:0]    KNOB_GAIN    = 15'd20;

  // (value + 1) in units of 1/10000
  localparam logic [TAB_W-1:0] SINE_TAB [SAMPLES_PER_PERIOD] = '{
    15'd10000, 15'd13090, 15'd15878, 15'd18090, 15'd19511,
    15'd20000, 15'd19511, 15'd18090, 15'd15878, 15'd13090,
    15'd10000, 15'd6910,  15'd4122,  15'd1910,  15'd489,
    15'd0,     15'd489,   15'd1910,  15'd4122,  15'd6910};

  localparam logic [TAB_W-1:0] TRI_TAB [SAMPLES_PER_PERIOD] = '{
    15'd10000, 15'd12000, 15'd14000, 15'd16000, 15'd18000,
    15'd19949, 15'd18000, 15'd16000, 15'd14000, 15'd12000,
    15'd10000, 15'd8000,  15'd6000,  15'd4000,  15'd2000,
    15'd51,    15'd2000,  15'd4000,  15'd6000,  15'd8000};

  // table entry pre-scaled by 255/5
  function automatic logic [SCALED_W-1:0] wave_scaled(input logic tri_sel,
                                                      input logic [ADDR_W-1:0] idx);
    logic [TAB_W-1:0] t;
    t = tri_sel ? TRI_TAB[idx] : SINE_TAB[idx];
    return SCALED_W'(t) * WAVE_GAIN;
  endfunction

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
  } store_cmd_t;

endpackage

FILE: rtl/twg_if.sv
// ----------------------------------------------------------------------------
// twg_if: request and response channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface twg_req_if;
  import twg_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   mode;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface twg_rsp_if;
  import twg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [DAC_W-1:0]        dac_value;
  logic                    dac_written;
  logic signed [POS_W-1:0] position;
  logic [LED_W-1:0]        led_level;

  modport source (output valid, output dac_value, output dac_written,
                  output position, output led_level, input ready);
  modport sink   (input valid, input dac_value, input dac_written,
                  input position, input led_level, output ready);
endinterface

FILE: rtl/twg_div.sv
// ----------------------------------------------------------------------------
// twg_div: shared iterative divider
// Restoring division, two quotient bits per cycle; done pulses for one
// cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module twg_div (
  input  logic              clk,
  input  logic              rst,
  input  twg_pkg::div_req_t req,
  output twg_pkg::div_rsp_t rsp
);
  import twg_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] count;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DIV_W-1:0]     quo;
  logic [DVS_W-1:0]     rem_next;
  logic [DIV_W-1:0]     quo_next;

  always_comb begin
    logic [DVS_W:0] trial;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial    = {rem_next, quo_next[DIV_W-1]};
      quo_next = {quo_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial       = trial - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: rtl/twg_store.sv
// ----------------------------------------------------------------------------
// twg_store: record sample store
// One write port, one registered read port. Per-entry valid bits make
// unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module twg_store (
  input  logic                          clk,
  input  logic                          rst,
  input  twg_pkg::store_cmd_t           cmd,
  output logic [twg_pkg::SAMPLE_W-1:0]  rd_data
);
  import twg_pkg::*;

  logic [SAMPLE_W-1:0]           mem [SAMPLES_PER_PERIOD];
  logic [SAMPLES_PER_PERIOD-1:0] filled;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (cmd.wr_en) begin
      filled[cmd.wr_addr] <= 1'b1;
    end
  end

  // one item in flight, so a read never meets a write to the same entry
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= filled[cmd.rd_addr] ? mem[cmd.rd_addr] : '0;
    end
  end

endmodule

FILE: rtl/table_wave_generator_record_playback.sv
// ----------------------------------------------------------------------------
// table_wave_generator_record_playback: table wave generator with record
// and playback
// Paces an 8-bit converter level from ticks, knob samples and start events.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per request: mode (0 tick, 1 start, 2 knob) and a
//   10-bit sample. rsp returns exactly one result per request: the current
//   converter level, whether this request wrote it, the table or buffer
//   position and the knob LED level.
//   Registers are written through wr_en/wr_index/wr_data while the block
//   is idle; writing the wave mode returns the position to idle (-1).
//   Flow: a request that ends a wave period, ends a playback period with the
//   position in range, or carries a nonzero knob sample passes through S_MUL
//   (operand setup), the shared divider in S_DIV (two quotient bits per step)
//   and S_DONE; all other requests go from S_IDLE straight to S_DONE.
//   Playback reads the sample store through its registered read port.
//   The result sits in an output register; a new request is taken while it
//   waits, but its own result stays in the sequencer until rsp drains.
//   Reset: wave mode normal, amplitude 2.5 V, 10-bit converter, period of
//   10 ticks, output enabled, level 0, store reads as all zeros.
// ----------------------------------------------------------------------------
module table_wave_generator_record_playback (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [twg_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [twg_pkg::CFG_DATA_W-1:0]   wr_data,
  twg_req_if.sink                          req,
  twg_rsp_if.source                        rsp
);
  import twg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    OP_WAVE,
    OP_PLAY,
    OP_KNOB
  } op_t;

  // configuration
  logic [MODE_W-1:0]       wave_mode;
  logic [AMP_W-1:0]        amplitude;
  logic                    adc_ten_bit;

  // block state
  state_t                  state;
  op_t                     op;
  logic signed [POS_W-1:0] pos;
  logic [TICK_W-1:0]       tick_count;
  logic [TICK_W-1:0]       period_ticks;
  logic                    out_en;
  logic [LED_W-1:0]        led;
  logic [DAC_W-1:0]        dac_level;
  logic                    written;
  logic [SAMPLE_W-1:0]     knob_sample;
  logic [SCALED_W-1:0]     wave_t;

  // output register
  logic                    out_valid;
  logic [DAC_W-1:0]        out_dac;
  logic                    out_written;
  logic signed [POS_W-1:0] out_pos;
  logic [LED_W-1:0]        out_led;

  div_req_t                div_req;
  div_rsp_t                div_rsp;
  store_cmd_t              store_cmd;
  logic [SAMPLE_W-1:0]     store_rd;

  logic                    accept;
  logic                    out_free;
  logic [SAMPLE_W-1:0]     fs;
  logic                    pos_ok;
  logic [ADDR_W-1:0]       wave_idx;
  logic [ADDR_W-1:0]       wave_idx_next;
  logic [TICK_W:0]         cnt_inc;
  logic                    period_hit;
  logic                    is_wave;
  logic                    tick_writes;
  logic                    needs_div;
  logic [LED_W+SAMPLE_W-1:0] k4;
  logic [LED_W+SAMPLE_W-1:0] k2;
  logic [LED_W+SAMPLE_W-1:0] fs_w;
  logic [LED_W+SAMPLE_W-1:0] fs3;
  logic [LED_W-1:0]        led_next;
  logic [DIV_W-2:0]        wave_prod;
  logic [SCALED_W-1:0]     play_prod;
  logic [TAB_W-1:0]        knob_num;
  logic [DAC_W-1:0]        div_sat;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign fs       = adc_ten_bit ? FS_TEN_BIT : FS_EIGHT_BIT;
  assign is_wave  = (wave_mode == MODE_SINE) || (wave_mode == MODE_TRIANGLE);

  // position -1 or past the end counts as out of range
  assign pos_ok        = !pos[POS_W-1] && (pos[ADDR_W-1:0] < ADDR_W'(SAMPLES_PER_PERIOD));
  assign wave_idx      = pos_ok ? pos[ADDR_W-1:0] : '0;
  assign wave_idx_next = (wave_idx == ADDR_W'(SAMPLES_PER_PERIOD - 1)) ? '0
                                                                       : wave_idx + 1'b1;

  assign cnt_inc    = {1'b0, tick_count} + 1'b1;
  assign period_hit = accept && (req.mode == KIND_TICK) && out_en &&
                      (cnt_inc >= {1'b0, period_ticks});

  // a tick writes the level when the output is off or a wave/playback period ends
  assign tick_writes = (req.mode == KIND_TICK) &&
                       (!out_en || (period_hit && (is_wave || (wave_mode == MODE_PLAYBACK))));
  assign needs_div   = (period_hit && (is_wave || ((wave_mode == MODE_PLAYBACK) && pos_ok))) ||
                       ((req.mode == KIND_KNOB) && (req.sample != '0));

  // knob quartile
  assign k4   = {req.sample, 2'b00};
  assign k2   = {1'b0, req.sample, 1'b0};
  assign fs_w = (LED_W + SAMPLE_W)'(fs);
  assign fs3  = fs_w + {fs_w[LED_W+SAMPLE_W-2:0], 1'b0};

  always_comb begin
    if (k4 < fs_w) begin
      led_next = 2'd0;
    end else if (k2 < fs_w) begin
      led_next = 2'd1;
    end else if (k4 < fs3) begin
      led_next = 2'd2;
    end else begin
      led_next = 2'd3;
    end
  end

  // store access happens on the accepting edge
  always_comb begin
    store_cmd.wr_en   = period_hit && (wave_mode == MODE_RECORD) && pos_ok;
    store_cmd.wr_addr = pos[ADDR_W-1:0];
    store_cmd.wr_data = req.sample;
    store_cmd.rd_en   = period_hit && (wave_mode == MODE_PLAYBACK) && pos_ok;
    store_cmd.rd_addr = pos[ADDR_W-1:0];
  end

  twg_store u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (store_cmd),
    .rd_data (store_rd)
  );

  // divider operands
  assign wave_prod = (DIV_W - 1)'(wave_t) * (DIV_W - 1)'(amplitude);
  assign play_prod = SCALED_W'(store_rd) * PLAY_GAIN;
  assign knob_num  = TAB_W'(fs) * KNOB_GAIN + TAB_W'(knob_sample);

  always_comb begin
    div_req.start = (state == S_MUL);
    case (op)
      OP_WAVE: begin
        div_req.dividend = {1'b0, wave_prod} + WAVE_BIAS;
        div_req.divisor  = WAVE_DIVISOR;
      end
      OP_PLAY: begin
        div_req.dividend = DIV_W'(play_prod) + DIV_W'(fs);
        div_req.divisor  = DVS_W'({fs, 1'b0});
      end
      OP_KNOB: begin
        div_req.dividend = DIV_W'(knob_num);
        div_req.divisor  = DVS_W'({knob_sample, 1'b0});
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = WAVE_DIVISOR;
      end
    endcase
  end

  twg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign div_sat = (div_rsp.quotient > DIV_W'(8'hFF)) ? 8'hFF
                                                      : div_rsp.quotient[DAC_W-1:0];

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      knob_sample <= req.sample;
      wave_t      <= wave_scaled(wave_mode == MODE_TRIANGLE, wave_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_WAVE;
      wave_mode    <= MODE_NORMAL;
      amplitude    <= AMP_MAX;
      adc_ten_bit  <= 1'b1;
      pos          <= '1;
      tick_count   <= '0;
      period_ticks <= PERIOD_RESET;
      out_en       <= 1'b1;
      led          <= '0;
      dac_level    <= '0;
      written      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            written <= tick_writes;
            state   <= needs_div ? S_MUL : S_DONE;
            case (req.mode)
              KIND_TICK: begin
                if (!out_en) begin
                  dac_level <= '0;
                end else if (!period_hit) begin
                  tick_count <= cnt_inc[TICK_W-1:0];
                end else begin
                  tick_count <= '0;
                  if (wave_mode == MODE_RECORD) begin
                    if (pos_ok) begin
                      pos <= pos + 6'sd1;
                    end
                  end else if (is_wave) begin
                    pos <= {1'b0, wave_idx_next};
                    op  <= OP_WAVE;
                  end else if (wave_mode == MODE_PLAYBACK) begin
                    if (pos_ok) begin
                      pos <= pos + 6'sd1;
                      op  <= OP_PLAY;
                    end else begin
                      dac_level <= '0;
                    end
                  end
                end
              end
              KIND_START: begin
                if (wave_mode inside {MODE_RECORD, MODE_PLAYBACK}) begin
                  pos <= '0;
                end else if (is_wave && (amplitude < AMP_MAX)) begin
                  amplitude <= amplitude + 1'b1;
                end
              end
              KIND_KNOB: begin
                led <= led_next;
                if (req.sample == '0) begin
                  out_en <= 1'b0;
                end else begin
                  out_en <= 1'b1;
                  op     <= OP_KNOB;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (op == OP_KNOB) begin
              period_ticks <= div_rsp.quotient[TICK_W-1:0];
            end else begin
              dac_level <= div_sat;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // register writes must arrive only while idle; the block itself does not enforce this
      if (wr_en) begin
        case (wr_index)
          REG_WAVE_MODE: begin
            wave_mode <= wr_data[MODE_W-1:0];
            pos       <= '1;
          end
          REG_AMPLITUDE:   amplitude   <= wr_data[AMP_W-1:0];
          REG_ADC_TEN_BIT: adc_ten_bit <= wr_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_dac     <= dac_level;
      out_written <= written;
      out_pos     <= pos;
      out_led     <= led;
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.dac_value   = out_dac;
  assign rsp.dac_written = out_written;
  assign rsp.position    = out_pos;
  assign rsp.led_level   = out_led;

  // checks
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while another is in flight");

  a_period_nonzero: assert property (@(posedge clk) disable iff (rst)
    period_ticks != '0)
    else $error("sample period became zero");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (pos == -6'sd1) || (!pos[POS_W-1] && (pos <= 6'sd20)))
    else $error("position out of range");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: table wave generator with record and playback
// Runs a directed table over the knob, start, tick and ignored request kinds,
// then random phases of sine, triangle, normal, playback, unused mode codes
// and record/playback work. An in-bench generator model forecasts each result,
// compared field by field in order, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import twg_pkg::*;

  localparam logic [KIND_W-1:0]    KIND_IGNORED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
  localparam int RANDOM_ITEMS = 1400;
  localparam int TIMEOUT_NS   = 1_000_000;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int MAX_PRINTED  = 40;

  // (value + 1) in units of 1/10000
  localparam int SINE_UNITS [SAMPLES_PER_PERIOD] = '{
    10000, 13090, 15878, 18090, 19511, 20000, 19511, 18090, 15878, 13090,
    10000, 6910, 4122, 1910, 489, 0, 489, 1910, 4122, 6910};
  localparam int TRI_UNITS [SAMPLES_PER_PERIOD] = '{
    10000, 12000, 14000, 16000, 18000, 19949, 18000, 16000, 14000, 12000,
    10000, 8000, 6000, 4000, 2000, 51, 2000, 4000, 6000, 8000};

  typedef struct packed {
    logic [DAC_W-1:0]        dac;
    logic                    written;
    logic signed [POS_W-1:0] pos;
    logic [LED_W-1:0]        led;
  } result_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [KIND_W-1:0]     kind;
    logic [SAMPLE_W-1:0]   smp;
    logic                  typed;
    result_t               want;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  twg_req_if req_ch();
  twg_rsp_if rsp_ch();

  table_wave_generator_record_playback dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // generator model state
  logic [MODE_W-1:0] gen_mode;
  int gen_amp, gen_ten, gen_pos, gen_ticks, gen_period;
  int gen_enabled, gen_led, gen_level;
  int gen_store [SAMPLES_PER_PERIOD];

  result_t outputs_due [$];
  bit calm;
  int stall_left;
  int item_goal;
  int errors, items_sent, ignored_sent, writes_done, results_checked, level_writes;

  always #1 clk = ~clk;

  task automatic report_error(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, what);
  endtask

  function automatic result_t advance_generator(input logic [KIND_W-1:0] kind,
                                                input logic [SAMPLE_W-1:0] smp);
    result_t r;
    int fs, k, v, p;
    logic wrote;
    fs = gen_ten ? 1023 : 255;
    k = int'(smp);
    wrote = 1'b0;
    case (kind)
      KIND_TICK: begin
        if (!gen_enabled) begin
          // output off: level forced low, counter holds
          gen_level = 0;
          wrote = 1'b1;
        end else begin
          gen_ticks++;
          if (gen_ticks >= gen_period) begin
            gen_ticks = 0;
            if (gen_mode == MODE_RECORD) begin
              if (gen_pos >= 0 && gen_pos < SAMPLES_PER_PERIOD) begin
                gen_store[gen_pos] = k;
                gen_pos++;
              end
            end else if (gen_mode == MODE_SINE || gen_mode == MODE_TRIANGLE) begin
              p = (gen_pos >= 0 && gen_pos < SAMPLES_PER_PERIOD) ? gen_pos : 0;
              v = (gen_mode == MODE_SINE) ? SINE_UNITS[p] : TRI_UNITS[p];
              v = (v * gen_amp * 51 + 50000) / 100000;
              gen_level = (v > 255) ? 255 : v;
              gen_pos = (p + 1) % SAMPLES_PER_PERIOD;
              wrote = 1'b1;
            end else if (gen_mode == MODE_PLAYBACK) begin
              v = 0;
              if (gen_pos >= 0 && gen_pos < SAMPLES_PER_PERIOD) begin
                v = (510 * gen_store[gen_pos] + fs) / (2 * fs);
                if (v > 255) v = 255;
                gen_pos++;
              end
              gen_level = v;
              wrote = 1'b1;
            end
          end
        end
      end
      KIND_START: begin
        if (gen_mode == MODE_RECORD || gen_mode == MODE_PLAYBACK) begin
          gen_pos = 0;
        end else if ((gen_mode == MODE_SINE || gen_mode == MODE_TRIANGLE) &&
                     gen_amp < int'(AMP_MAX)) begin
          gen_amp++;
        end
      end
      KIND_KNOB: begin
        if (k == 0) begin
          gen_enabled = 0;
        end else begin
          gen_enabled = 1;
          gen_period = (20 * fs + k) / (2 * k);
        end
        if (4 * k < fs) gen_led = 0;
        else if (2 * k < fs) gen_led = 1;
        else if (4 * k < 3 * fs) gen_led = 2;
        else gen_led = 3;
      end
      default: ;
    endcase
    r.dac = DAC_W'(gen_level);
    r.written = wrote;
    r.pos = POS_W'(gen_pos);
    r.led = LED_W'(gen_led);
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  function automatic plan_row_t item_row(input logic [KIND_W-1:0] kind,
                                         input logic [SAMPLE_W-1:0] smp);
    plan_row_t row;
    row = '0;
    row.kind = kind;
    row.smp = smp;
    return row;
  endfunction

  function automatic plan_row_t checked_row(input logic [KIND_W-1:0] kind,
                                            input logic [SAMPLE_W-1:0] smp,
                                            input int dac, input int wr,
                                            input int pos, input int led);
    plan_row_t row;
    row = item_row(kind, smp);
    row.typed = 1'b1;
    row.want.dac = DAC_W'(dac);
    row.want.written = wr[0];
    row.want.pos = POS_W'(pos);
    row.want.led = LED_W'(led);
    return row;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return SAMPLE_W'($urandom_range(1023));
  endfunction

  // mostly short periods so outputs come often; sometimes any value or off
  function automatic logic [SAMPLE_W-1:0] pick_knob();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return SAMPLE_W'($urandom_range(1023));
    return gen_ten ? SAMPLE_W'($urandom_range(900, 1023)) : SAMPLE_W'($urandom_range(450, 1023));
  endfunction

  // enough ticks to walk the whole buffer and run past its end at short periods; capped at 250
  function automatic int buffer_span();
    int n;
    n = 22 * gen_period + 5;
    return (n > 250) ? 250 : n;
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [SAMPLE_W-1:0] smp,
                              input logic typed, input result_t want);
    result_t forecast;
    if (!calm && $urandom_range(99) < 6) begin
      if (req_ch.valid) req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.mode   <= kind;
    req_ch.sample <= smp;
    do @(posedge clk); while (!req_ch.ready);
    forecast = advance_generator(kind, smp);
    outputs_due.push_back(typed ? want : forecast);
    if (kind == KIND_IGNORED) ignored_sent++;
    else items_sent++;
  endtask

  task automatic send_plain(input logic [KIND_W-1:0] kind, input logic [SAMPLE_W-1:0] smp);
    send_request(kind, smp, 1'b0, '0);
  endtask

  task automatic wait_for_results();
    if (req_ch.valid) req_ch.valid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    wait_for_results();
    repeat (4) @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_WAVE_MODE: begin
        gen_mode = val[MODE_W-1:0];
        gen_pos = -1;
      end
      REG_AMPLITUDE:   gen_amp = int'(val);
      REG_ADC_TEN_BIT: gen_ten = int'(val[0]);
      default: ;
    endcase
    writes_done++;
  endtask

  // upper data bits are don't-care for the mode register
  task automatic write_mode(input logic [MODE_W-1:0] m);
    write_register(REG_WAVE_MODE,
                   {($urandom_range(7) == 0) ? 2'($urandom_range(3)) : 2'b00, m});
  endtask

  task automatic run_phase(input int n);
    int r;
    repeat (n) begin
      if (items_sent >= item_goal) break;
      r = $urandom_range(99);
      if (r < 2) wait_for_results();
      if (r < 84) send_plain(KIND_TICK, pick_sample());
      else if (r < 90) send_plain(KIND_KNOB, pick_knob());
      else if (r < 96) send_plain(KIND_START, pick_sample());
      else send_plain(KIND_IGNORED, pick_sample());
    end
  endtask

  task automatic check_result();
    result_t want;
    if (outputs_due.size() == 0) begin
      report_error($sformatf("result with nothing pending: dac=%0d written=%0b",
                             rsp_ch.dac_value, rsp_ch.dac_written));
      return;
    end
    want = outputs_due.pop_front();
    results_checked++;
    if (want.written) level_writes++;
    if (rsp_ch.dac_value !== want.dac)
      report_error($sformatf("dac_value %0d, expected %0d", rsp_ch.dac_value, want.dac));
    if (rsp_ch.dac_written !== want.written)
      report_error($sformatf("dac_written %0b, expected %0b",
                             rsp_ch.dac_written, want.written));
    if (rsp_ch.position !== want.pos)
      report_error($sformatf("position %0d, expected %0d", rsp_ch.position, want.pos));
    if (rsp_ch.led_level !== want.led)
      report_error($sformatf("led_level %0d, expected %0d", rsp_ch.led_level, want.led));
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) check_result();
    if (stall_left > 0) stall_left--;
    else if (!calm && $urandom_range(99) < 6) stall_left = 1;
    rsp_ch.ready <= !rst && stall_left == 0;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Timeout with %0d results still pending", outputs_due.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    plan_row_t plan [$];
    int r, phase, waited, directed_items;

    clk = 1'b0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = '0;
    req_ch.sample = '0;
    rsp_ch.ready = 1'b0;
    calm = 1'b0;
    stall_left = 0;
    item_goal = RANDOM_ITEMS;

    gen_mode = MODE_NORMAL;
    gen_amp = int'(AMP_MAX);
    gen_ten = 1;
    gen_pos = -1;
    gen_ticks = 0;
    gen_period = int'(PERIOD_RESET);
    gen_enabled = 1;
    gen_led = 0;
    gen_level = 0;
    foreach (gen_store[i]) gen_store[i] = 0;

    plan = '{
      checked_row(KIND_IGNORED, 10'd1023, 0, 0, -1, 0),
      checked_row(KIND_KNOB, 10'd1023, 0, 0, -1, 3),
      checked_row(KIND_KNOB, 10'd0, 0, 0, -1, 0),
      checked_row(KIND_TICK, 10'd512, 0, 1, -1, 0),      // output off
      cfg_row(REG_ADC_TEN_BIT, 5'd0),
      checked_row(KIND_KNOB, 10'd1023, 0, 0, -1, 3),     // period of two
      cfg_row(REG_WAVE_MODE, 5'(MODE_SINE)),
      checked_row(KIND_START, 10'd0, 0, 0, -1, 3),       // amplitude already at top
      checked_row(KIND_TICK, 10'd0, 0, 0, -1, 3),
      checked_row(KIND_TICK, 10'd0, 128, 1, 1, 3),       // idle position reads entry 0
      cfg_row(REG_AMPLITUDE, 5'd31),
      item_row(KIND_TICK, 10'd1),
      item_row(KIND_TICK, 10'd2),
      item_row(KIND_TICK, 10'd4),
      item_row(KIND_TICK, 10'd8),
      item_row(KIND_TICK, 10'd16),
      checked_row(KIND_TICK, 10'd32, 255, 1, 4, 3),      // saturates
      cfg_row(REG_AMPLITUDE, 5'd0),
      cfg_row(REG_WAVE_MODE, 5'(MODE_TRIANGLE)),
      checked_row(KIND_START, 10'd0, 255, 0, -1, 3),
      cfg_row(REG_WAVE_MODE, 5'(MODE_RECORD)),
      checked_row(KIND_START, 10'd0, 255, 0, 0, 3),
      item_row(KIND_TICK, 10'd1023),
      checked_row(KIND_TICK, 10'd1023, 255, 0, 1, 3),
      cfg_row(REG_WAVE_MODE, 5'(MODE_PLAYBACK)),
      item_row(KIND_TICK, 10'd0),
      checked_row(KIND_TICK, 10'd0, 0, 1, -1, 3),        // playback before start
      checked_row(KIND_START, 10'd0, 0, 0, 0, 3),
      item_row(KIND_TICK, 10'd0),
      checked_row(KIND_TICK, 10'd0, 255, 1, 1, 3)        // stored value above 8-bit scale
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_register(plan[i].idx, plan[i].val);
      else send_request(plan[i].kind, plan[i].smp, plan[i].typed, plan[i].want);
    end
    directed_items = items_sent;
    item_goal = directed_items + RANDOM_ITEMS;

    phase = 0;
    while (items_sent < item_goal) begin
      calm = (phase >= 5 && phase < 9);
      if ($urandom_range(2) == 0)
        write_register(REG_ADC_TEN_BIT, {4'($urandom_range(15)), ($urandom_range(9) < 3)});
      r = $urandom_range(99);
      write_register(REG_AMPLITUDE, (r < 10) ? 5'($urandom_range(26, 31)) :
                                    (r < 20) ? 5'd0 :
                                    (r < 30) ? AMP_MAX : 5'($urandom_range(24)));
      if ($urandom_range(19) == 0) write_register(REG_UNUSED, 5'($urandom_range(31)));

      r = $urandom_range(99);
      if (r < 30) begin
        write_mode(MODE_RECORD);
        send_plain(KIND_KNOB, pick_knob());
        send_plain(KIND_START, pick_sample());
        run_phase(buffer_span());
        if ($urandom_range(3) == 0)
          write_register(REG_ADC_TEN_BIT, {4'($urandom_range(15)), 1'($urandom_range(1))});
        write_mode(MODE_PLAYBACK);
        send_plain(KIND_START, pick_sample());
        run_phase(buffer_span());
      end else begin
        if (r < 55) write_mode(MODE_SINE);
        else if (r < 75) write_mode(MODE_TRIANGLE);
        else if (r < 88) write_mode(MODE_PLAYBACK);
        else if (r < 94) write_mode(MODE_NORMAL);
        else write_mode(3'($urandom_range(5, 7)));
        send_plain(KIND_KNOB, pick_knob());
        run_phase($urandom_range(30, 90));
      end
      phase++;
    end

    if (req_ch.valid) req_ch.valid <= 1'b0;
    waited = 0;
    while (outputs_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (outputs_due.size() != 0)
      report_error($sformatf("%0d results never arrived", outputs_due.size()));

    $display("Sent %0d requests plus %0d ignored kinds over %0d phases, %0d register writes",
             items_sent, ignored_sent, phase, writes_done);
    $display("Checked %0d results, %0d of them converter writes", results_checked,
             level_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/twg_pkg.sv
rtl/twg_if.sv
rtl/twg_div.sv
rtl/twg_store.sv
rtl/table_wave_generator_record_playback.sv
verif/tb_top.sv
